### src/wmcs_pkg.sv
`default_nettype none

package wmcs_pkg;

  localparam int unsigned WHEELS_DEF = 4;
  localparam int unsigned NUM_CMD_ID = 4;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned ID_W   = 29;
  localparam int unsigned STS_W  = 8;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned MODE_W = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = ID_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SET_SPEED = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ESTOP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FEEDBACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 3'd5;

  // sequencer modes
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CMD_ID0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_ID1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_ID2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_ID3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_BASE = 3'd4;

  localparam logic [ID_W-1:0] FB_BASE_RST = 29'h110;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        motor_index;
    logic signed [SPD_W-1:0] speed;
    logic [ID_W-1:0]         rx_id;
    logic [STS_W-1:0]        rx_status;
    logic signed [POS_W-1:0] rx_position;
  } wmcs_in_t;

  typedef struct packed {
    logic                    frame_valid;
    logic [ID_W-1:0]         frame_id;
    logic signed [SPD_W-1:0] frame_speed;
    logic                    frame_enable;
    logic [MODE_W-1:0]       mode_now;
    logic                    estop_latched;
    logic                    last;
  } wmcs_out_t;

endpackage

`default_nettype wire

### src/wmcs_if.sv
`default_nettype none

interface wmcs_in_if;
  import wmcs_pkg::*;
  logic     valid;
  logic     ready;
  wmcs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wmcs_out_if;
  import wmcs_pkg::*;
  logic      valid;
  logic      ready;
  wmcs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/wmcs_ram.sv
`default_nettype none

module wmcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/wheel_motor_command_sequencer.sv
`default_nettype none

// Wheel command sequencer for up to WHEELS motors. Each input transaction is a
// command (set speed, stop, emergency stop, tick, feedback frame, heartbeat);
// it yields one to WHEELS output transactions, each a speed-command frame
// (bus id, signed speed, enable) or a single status-only result, and the last
// one of the group carries last=1. The speed table lives in a small RAM with a
// registered read and is walked one wheel per cycle while the output is not
// stalled. A frame for every wheel from stored speeds (set speed from idle,
// resume from stopped, tick) goes through the accept cycle, a read of the first
// table entry, then one frame per cycle while the next entry is read, as long
// as the output does not stall; stop and emergency stop skip the read, since
// the zero frames need none, as do a single frame and a status-only result.
// The output register lets a new input be taken while the final result of the
// previous one still waits. Stop clears the speed table at once through
// per-wheel valid bits. The user must write command ids and the feedback base
// id through the cfg port only while the block is idle; the block itself does
// not enforce this.

module wheel_motor_command_sequencer #(
  parameter int unsigned WHEELS = wmcs_pkg::WHEELS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  wmcs_in_if.sink                               in_i,
  wmcs_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [wmcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wmcs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import wmcs_pkg::*;

  localparam int unsigned WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam logic [WIDX-1:0]  LAST_WHEEL = WIDX'(WHEELS - 1);
  localparam logic [IDX_W-1:0] WHEELS_IDX = IDX_W'(WHEELS);
  localparam logic [ID_W-1:0]  WHEELS_ID  = ID_W'(WHEELS);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  // what an accepted command asks of the sequencer
  typedef enum logic [1:0] {
    JOB_STATUS,   // one status-only result
    JOB_ONE,      // one frame with the requested speed
    JOB_ALL,      // one frame per wheel from the speed table
    JOB_ZERO      // one zero-speed frame per wheel
  } wmcs_job_e;

  // control state
  logic [1:0]        state_q, state_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              estop_q, estop_d;
  logic              drive_q, drive_d;
  logic [WHEELS-1:0] spd_vld_q;
  logic [WIDX-1:0]   wcnt_q, wcnt_d;
  logic              out_valid_q, out_valid_d;

  // configuration
  logic [ID_W-1:0]   cmd_id_q [NUM_CMD_ID];
  logic [ID_W-1:0]   fb_base_q;

  // job and output payload
  wmcs_job_e         job_q, job_d;
  logic              job_en_q;
  logic [WIDX-1:0]   job_wheel_q;
  logic [SPD_W-1:0]  job_speed_q;
  logic              rd_vld_q;
  wmcs_out_t         out_data_q, out_data_d;

  // input decode
  wmcs_in_t          in_data;
  logic              in_acc;
  logic              idx_ok;
  logic [WIDX-1:0]   idx_w;
  logic [ID_W:0]     fb_diff;
  logic              fb_hit;
  logic              spd_we;
  logic              fb_we;
  logic              zero_all;

  // table walk
  logic              rd_en;
  logic [WIDX-1:0]   rd_addr;
  logic [SPD_W-1:0]  rd_data;
  logic              out_free;
  logic              load;
  logic              is_last;
  logic [WIDX-1:0]   cur_wheel;
  logic [SPD_W-1:0]  cur_speed;

  assign in_data     = in_i.data;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;

  assign idx_ok  = (in_data.motor_index < WHEELS_IDX);
  assign idx_w   = in_data.motor_index[WIDX-1:0];

  // feedback window: base <= rx_id < base + WHEELS, without wrap
  assign fb_diff = {1'b0, in_data.rx_id} - {1'b0, fb_base_q};
  assign fb_hit  = !fb_diff[ID_W] && (fb_diff[ID_W-1:0] < WHEELS_ID);

  // mode decode for the accepted command
  always_comb begin
    mode_d   = mode_q;
    estop_d  = estop_q;
    drive_d  = drive_q;
    job_d    = JOB_STATUS;
    spd_we   = 1'b0;
    fb_we    = 1'b0;
    zero_all = 1'b0;
    case (mode_q)
      MODE_IDLE: begin
        if (in_data.cmd == CMD_SET_SPEED) begin
          spd_we  = idx_ok;
          drive_d = 1'b1;
          mode_d  = MODE_RUN;
          job_d   = JOB_ALL;
        end
      end
      MODE_RUN: begin
        case (in_data.cmd)
          CMD_SET_SPEED: begin
            if (idx_ok) begin
              spd_we = 1'b1;
              job_d  = JOB_ONE;
            end
          end
          CMD_STOP, CMD_ESTOP: begin
            // zero frames still go out with the running enable value
            zero_all = 1'b1;
            drive_d  = 1'b0;
            mode_d   = MODE_STOP;
            job_d    = JOB_ZERO;
            if (in_data.cmd == CMD_ESTOP) begin
              estop_d = 1'b1;
            end
          end
          CMD_TICK: begin
            job_d = JOB_ALL;
          end
          CMD_FEEDBACK: begin
            fb_we = fb_hit;
          end
          default: begin
          end
        endcase
      end
      default: begin
        // stopped
        if (in_data.cmd == CMD_SET_SPEED) begin
          if (!estop_q) begin
            drive_d = 1'b1;
            mode_d  = MODE_RUN;
            job_d   = JOB_ALL;
          end
        end else if (in_data.cmd == CMD_HEARTBEAT) begin
          estop_d = 1'b0;
          drive_d = 1'b0;
          mode_d  = MODE_IDLE;
        end
      end
    endcase
  end

  // speed table, one entry per wheel
  wmcs_ram #(
    .WIDTH (SPD_W),
    .DEPTH (WHEELS)
  ) u_spd_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && spd_we),
    .waddr_i (idx_w),
    .wdata_i (SPD_W'(in_data.speed)),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // feedback store: status and position per wheel
  wmcs_ram #(
    .WIDTH (STS_W + POS_W),
    .DEPTH (WHEELS)
  ) u_fb_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && fb_we),
    .waddr_i (fb_diff[WIDX-1:0]),
    .wdata_i ({in_data.rx_status, POS_W'(in_data.rx_position)}),
    .re_i    (1'b0),
    .raddr_i ('0),
    .rdata_o ()
  );

  // frame fields for the current step of the walk
  assign out_free  = !out_valid_q || out_o.ready;
  assign cur_wheel = (job_q == JOB_ONE) ? job_wheel_q : wcnt_q;
  assign is_last   = (job_q == JOB_ONE) || (job_q == JOB_STATUS) ||
                     (wcnt_q == LAST_WHEEL);

  always_comb begin
    case (job_q)
      JOB_ALL: cur_speed = rd_vld_q ? rd_data : '0;
      JOB_ONE: cur_speed = job_speed_q;
      default: cur_speed = '0;
    endcase
  end

  // sequencer: for a table walk read the first entry, then emit one frame per
  // cycle while the output is free and the next entry is read
  always_comb begin
    state_d = state_q;
    wcnt_d  = wcnt_q;
    rd_en   = 1'b0;
    rd_addr = wcnt_q;
    load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          wcnt_d  = '0;
          state_d = (job_d == JOB_ALL) ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        // table write of the accept cycle has landed by now
        rd_en   = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            wcnt_d  = wcnt_q + 1'b1;
            rd_addr = wcnt_q + 1'b1;
            rd_en   = (job_q == JOB_ALL);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_d               = out_data_q;
    out_valid_d              = out_valid_q && !out_o.ready;
    if (load) begin
      out_valid_d                = 1'b1;
      out_data_d.frame_valid     = (job_q != JOB_STATUS);
      out_data_d.frame_id        = (job_q != JOB_STATUS) ? cmd_id_q[2'(cur_wheel)] : '0;
      out_data_d.frame_speed     = cur_speed;
      out_data_d.frame_enable    = (job_q != JOB_STATUS) && job_en_q;
      out_data_d.mode_now        = mode_q;
      out_data_d.estop_latched   = estop_q;
      out_data_d.last            = is_last;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_IDLE;
      estop_q     <= 1'b0;
      drive_q     <= 1'b0;
      spd_vld_q   <= '0;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
      job_q       <= JOB_STATUS;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        mode_q  <= mode_d;
        estop_q <= estop_d;
        drive_q <= drive_d;
        job_q   <= job_d;
        if (zero_all) begin
          spd_vld_q <= '0;
        end else if (spd_we) begin
          spd_vld_q[idx_w] <= 1'b1;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CMD_ID; i++) begin
        cmd_id_q[i] <= '0;
      end
      fb_base_q <= FB_BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CMD_ID0: cmd_id_q[0] <= cfg_data_i;
        REG_CMD_ID1: cmd_id_q[1] <= cfg_data_i;
        REG_CMD_ID2: cmd_id_q[2] <= cfg_data_i;
        REG_CMD_ID3: cmd_id_q[3] <= cfg_data_i;
        REG_FB_BASE: fb_base_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      // stop frames carry the enable value from before the stop
      job_en_q    <= (job_d == JOB_ZERO) ? drive_q : drive_d;
      job_wheel_q <= idx_w;
      job_speed_q <= SPD_W'(in_data.speed);
    end
    if (rd_en) begin
      rd_vld_q <= spd_vld_q[rd_addr];
    end
    out_data_q <= out_data_d;
  end

  // drive enable follows the running mode
  a_drive_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q == (mode_q == MODE_RUN))
    else $error("drive enable out of step with mode");

  // the latch only stands while stopped
  a_estop_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    estop_q |-> (mode_q == MODE_STOP))
    else $error("estop latched outside stopped mode");

  // a pending non-final result means the sequencer still owes frames
  a_group_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.last) |-> (state_q != S_IDLE))
    else $error("sequencer idle with a frame group open");

  // stop clears the whole speed table
  a_stop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && zero_all) |=> (spd_vld_q == '0))
    else $error("speed table not cleared by stop");

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wmcs_pkg::*;

  // codes the block treats as reserved
  localparam logic [CMD_W-1:0]     CMD_RSVD6       = 3'd6;
  localparam logic [CMD_W-1:0]     CMD_RSVD7       = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam int unsigned WHEELS       = WHEELS_DEF;
  localparam int unsigned IDLE_PCT     = 19;
  // longest walk of the wheel table plus the output register, with margin
  localparam int unsigned DRAIN_CYCLES = 2 * WHEELS + 6;
  localparam int unsigned QUIET_LIMIT  = 5000;

  localparam logic [ID_W-1:0]         ID_MAX  = '1;
  localparam logic signed [SPD_W-1:0] SPD_MIN = 16'h8000;
  localparam logic signed [SPD_W-1:0] SPD_MAX = 16'h7FFF;

  // tracks the sequencer state and the frames it must emit, in order
  class wheel_frame_checker;
    wmcs_out_t               frames_due[$];
    wmcs_out_t               group[$];
    logic [ID_W-1:0]         cmd_id [NUM_CMD_ID];
    logic [ID_W-1:0]         fb_base;
    logic [MODE_W-1:0]       mode;
    logic signed [SPD_W-1:0] speed_tab [WHEELS];
    logic [STS_W-1:0]        status_tab [WHEELS];
    logic signed [POS_W-1:0] pos_tab [WHEELS];
    logic                    estop;
    logic                    drive_en;
    int unsigned             mismatches = 0;
    int unsigned             frames_seen = 0;
    int unsigned             cmds_seen = 0;

    function void reset_state();
      for (int w = 0; w < NUM_CMD_ID; w++) cmd_id[w] = '0;
      for (int w = 0; w < WHEELS; w++) begin
        speed_tab[w]  = '0;
        status_tab[w] = '0;
        pos_tab[w]    = '0;
      end
      fb_base  = FB_BASE_RST;
      mode     = MODE_IDLE;
      estop    = 1'b0;
      drive_en = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < NUM_CMD_ID) cmd_id[idx] = data;
      else if (idx == REG_FB_BASE) fb_base = data;
    endfunction

    function void add_frame(int unsigned w, logic signed [SPD_W-1:0] spd);
      wmcs_out_t r;
      r              = '0;
      r.frame_valid  = 1'b1;
      r.frame_id     = cmd_id[w];
      r.frame_speed  = spd;
      r.frame_enable = drive_en;
      group.push_back(r);
    endfunction

    function void send_all();
      for (int w = 0; w < WHEELS; w++) add_frame(w, speed_tab[w]);
    endfunction

    // zero frames go out with the enable still set, then the drive drops
    function void stop_all();
      for (int w = 0; w < WHEELS; w++) begin
        speed_tab[w] = '0;
        add_frame(w, '0);
      end
      drive_en = 1'b0;
      mode     = MODE_STOP;
    endfunction

    // returns 1 when the command did something beyond a status result
    function bit accept_command(wmcs_in_t t);
      logic [MODE_W-1:0] mode_was;
      logic              estop_was;
      logic [ID_W:0]     offset;
      bit                idx_ok;
      bit                in_window;
      bit                stored;
      wmcs_out_t         r;
      idx_ok    = t.motor_index < WHEELS;
      offset    = {1'b0, t.rx_id} - {1'b0, fb_base};
      in_window = (t.rx_id >= fb_base) && (offset < WHEELS);
      mode_was  = mode;
      estop_was = estop;
      stored    = 1'b0;
      cmds_seen++;
      group.delete();
      case (mode)
        MODE_IDLE: begin
          if (t.cmd == CMD_SET_SPEED) begin
            if (idx_ok) speed_tab[t.motor_index] = t.speed;
            drive_en = 1'b1;
            mode     = MODE_RUN;
            send_all();
          end
        end
        MODE_RUN: begin
          case (t.cmd)
            CMD_SET_SPEED: begin
              if (idx_ok) begin
                speed_tab[t.motor_index] = t.speed;
                add_frame(t.motor_index, t.speed);
              end
            end
            CMD_STOP: stop_all();
            CMD_ESTOP: begin
              estop = 1'b1;
              stop_all();
            end
            CMD_TICK: send_all();
            CMD_FEEDBACK: begin
              if (in_window) begin
                status_tab[offset] = t.rx_status;
                pos_tab[offset]    = t.rx_position;
                stored             = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: begin
          if (t.cmd == CMD_SET_SPEED && !estop) begin
            drive_en = 1'b1;
            mode     = MODE_RUN;
            send_all();
          end else if (t.cmd == CMD_HEARTBEAT) begin
            estop    = 1'b0;
            drive_en = 1'b0;
            mode     = MODE_IDLE;
          end
        end
      endcase
      accept_command = group.size() != 0 || mode != mode_was || estop != estop_was || stored;
      if (group.size() == 0) group.push_back('0);
      foreach (group[i]) begin
        r               = group[i];
        r.mode_now      = mode;
        r.estop_latched = estop;
        r.last          = (i == group.size() - 1);
        frames_due.push_back(r);
      end
    endfunction

    function void check_frame(wmcs_out_t got);
      wmcs_out_t want;
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: id=%h spd=%0d mode=%0d last=%0b",
                   $realtime, got.frame_id, got.frame_speed, got.mode_now, got.last);
        return;
      end
      want = frames_due.pop_front();
      frames_seen++;
      if (got.frame_valid !== want.frame_valid || got.frame_id !== want.frame_id ||
          got.frame_speed !== want.frame_speed || got.frame_enable !== want.frame_enable ||
          got.mode_now !== want.mode_now || got.estop_latched !== want.estop_latched ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0d expected vld=%0b id=%h spd=%0d en=%0b mode=%0d estop=%0b last=%0b",
                   $realtime, frames_seen, want.frame_valid, want.frame_id, want.frame_speed,
                   want.frame_enable, want.mode_now, want.estop_latched, want.last);
          $display("%0t: result %0d actual   vld=%0b id=%h spd=%0d en=%0b mode=%0d estop=%0b last=%0b",
                   $realtime, frames_seen, got.frame_valid, got.frame_id, got.frame_speed,
                   got.frame_enable, got.mode_now, got.estop_latched, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  wmcs_in_if  in_if ();
  wmcs_out_if out_if ();

  wheel_frame_checker frame_chk;
  bit                 steady;       // no idling on either side while set
  int unsigned        useful_cmds;  // commands that did more than report status
  int unsigned        quiet_cycles;

  wheel_motor_command_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side backpressure, off during the steady stretch
  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // every accepted result goes to the checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) frame_chk.check_frame(out_if.data);
  end

  // watchdog: too long without any transaction or register write ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, frame_chk.frames_due.size());
      $display("wheel_motor_command_sequencer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ID_W-1:0] rand_id();
    case ($urandom_range(3))
      0:       rand_id = '0;
      1:       rand_id = ID_MAX;
      default: rand_id = ID_W'($urandom);
    endcase
  endfunction

  // mostly a real wheel, sometimes any index
  function automatic logic [IDX_W-1:0] rand_index();
    if ($urandom_range(99) < 80) rand_index = IDX_W'($urandom_range(WHEELS - 1));
    else rand_index = IDX_W'($urandom);
  endfunction

  function automatic logic signed [SPD_W-1:0] rand_speed();
    case ($urandom_range(9))
      0:       rand_speed = SPD_MIN;
      1:       rand_speed = SPD_MAX;
      default: rand_speed = SPD_W'($urandom);
    endcase
  endfunction

  // command with random content in the fields it does not use
  function automatic wmcs_in_t make_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                        logic signed [SPD_W-1:0] spd);
    wmcs_in_t item;
    item.cmd         = cmd;
    item.motor_index = idx;
    item.speed       = spd;
    item.rx_id       = ID_W'($urandom);
    item.rx_status   = STS_W'($urandom);
    item.rx_position = $urandom;
    return item;
  endfunction

  function automatic wmcs_in_t make_feedback(logic [ID_W-1:0] id);
    wmcs_in_t item;
    item       = make_cmd(CMD_FEEDBACK, IDX_W'($urandom), SPD_W'($urandom));
    item.rx_id = id;
    return item;
  endfunction

  // weighted by the mode so that most traffic walks through all three modes
  function automatic wmcs_in_t pick_cmd();
    int unsigned roll;
    wmcs_in_t    item;
    roll = $urandom_range(99);
    item = make_cmd(CMD_W'($urandom_range(7)), rand_index(), rand_speed());
    case (frame_chk.mode)
      MODE_IDLE: begin
        if (roll < 70) item.cmd = CMD_SET_SPEED;
      end
      MODE_RUN: begin
        if (roll < 35) begin
          item.cmd = CMD_SET_SPEED;
        end else if (roll < 55) begin
          item.cmd = CMD_TICK;
        end else if (roll < 75) begin
          item.cmd = CMD_FEEDBACK;
          // mostly inside the window, a few just past its upper edge
          if (roll < 68) item.rx_id = frame_chk.fb_base + ID_W'($urandom_range(WHEELS - 1));
          else if (roll < 72) item.rx_id = frame_chk.fb_base + ID_W'(WHEELS);
        end else if (roll < 83) begin
          item.cmd = CMD_STOP;
        end else if (roll < 90) begin
          item.cmd = CMD_ESTOP;
        end
      end
      default: begin
        if (roll < 40) item.cmd = CMD_SET_SPEED;
        else if (roll < 75) item.cmd = CMD_HEARTBEAT;
      end
    endcase
    return item;
  endfunction

  // present one command, idling at random, and hold it until taken
  task automatic send_cmd(input wmcs_in_t item);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk_i); while (!in_if.ready);
    if (frame_chk.accept_command(item)) useful_cmds++;
  endtask

  // let everything pending come out, then give the block time to settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (frame_chk.frames_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // rewrite all registers while the block is quiet, plus one unused index
  task automatic program_regs(input logic [ID_W-1:0] id0, input logic [ID_W-1:0] id1,
                              input logic [ID_W-1:0] id2, input logic [ID_W-1:0] id3,
                              input logic [ID_W-1:0] base);
    logic [ID_W-1:0]      vals [5];
    logic [CFG_IDX_W-1:0] spare;
    vals  = '{id0, id1, id2, id3, base};
    spare = CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST));
    drain();
    for (int r = 0; r <= REG_FB_BASE; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(r);
      cfg_data_i <= vals[r];
      @(posedge clk_i);
      frame_chk.write_reg(CFG_IDX_W'(r), vals[r]);
    end
    // an unused index must leave every register alone
    cfg_idx_i  <= spare;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    frame_chk.write_reg(spare, cfg_data_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned start;
    start = frame_chk.cmds_seen;
    while (frame_chk.cmds_seen - start < target) send_cmd(pick_cmd());
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    steady       = 1'b0;
    useful_cmds  = 0;
    frame_chk    = new;
    frame_chk.reset_state();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // alternating and extreme ids, feedback window at its reset place
    program_regs(ID_MAX, '0, 29'h0AAA_AAAA, 29'h1555_5555, FB_BASE_RST);

    // idle ignores everything but set speed
    send_cmd(make_cmd(CMD_TICK, 8'd0, 16'sd5));
    send_cmd(make_cmd(CMD_ESTOP, 8'd1, 16'sd5));
    send_cmd(make_feedback(FB_BASE_RST));
    send_cmd(make_cmd(CMD_HEARTBEAT, 8'd2, 16'sd5));
    send_cmd(make_cmd(CMD_RSVD6, 8'd3, 16'sd5));
    // start with the most negative speed, then single-wheel updates
    send_cmd(make_cmd(CMD_SET_SPEED, 8'd2, SPD_MIN));
    send_cmd(make_cmd(CMD_SET_SPEED, 8'd0, SPD_MAX));
    send_cmd(make_cmd(CMD_SET_SPEED, 8'd3, -16'sd1));
    // wheel index out of range sends no frame, only a status result
    send_cmd(make_cmd(CMD_SET_SPEED, 8'd255, 16'sd100));
    send_cmd(make_cmd(CMD_SET_SPEED, 8'd4, 16'sd100));
    send_cmd(make_cmd(CMD_TICK, 8'd0, 16'sd0));
    // both edges of the feedback window and just outside it
    send_cmd(make_feedback(FB_BASE_RST));
    send_cmd(make_feedback(FB_BASE_RST + 29'd3));
    send_cmd(make_feedback(FB_BASE_RST + 29'd4));
    send_cmd(make_feedback(FB_BASE_RST - 29'd1));
    send_cmd(make_cmd(CMD_HEARTBEAT, 8'd0, 16'sd0));
    send_cmd(make_cmd(CMD_RSVD7, 8'd0, 16'sd0));
    send_cmd(make_cmd(CMD_STOP, 8'd0, 16'sd0));
    // resume from stopped with a bad index: zero frames still go out
    send_cmd(make_cmd(CMD_SET_SPEED, 8'd9, 16'sd1));
    send_cmd(make_cmd(CMD_ESTOP, 8'd0, 16'sd0));
    // latch holds the block in stopped until a heartbeat
    send_cmd(make_cmd(CMD_SET_SPEED, 8'd1, 16'sd7));
    send_cmd(make_cmd(CMD_TICK, 8'd0, 16'sd0));
    send_cmd(make_cmd(CMD_HEARTBEAT, 8'd0, 16'sd0));
    send_cmd(make_cmd(CMD_SET_SPEED, 8'd200, 16'sd3));

    // random traffic under three register settings
    program_regs(rand_id(), rand_id(), rand_id(), rand_id(), '0);
    run_random(60);

    // window at the top of the id space, no idling for the whole phase
    program_regs('0, ID_MAX, '0, ID_MAX, ID_MAX);
    steady = 1'b1;
    run_random(56);
    steady = 1'b0;

    program_regs(rand_id(), rand_id(), rand_id(), rand_id(), rand_id());
    run_random(60);

    drain();
    $display("ran %0d commands (%0d with an effect), %0d results checked, %0d mismatches",
             frame_chk.cmds_seen, useful_cmds, frame_chk.frames_seen, frame_chk.mismatches);
    $display("covered all modes, latch set and clear, four register settings with id extremes");
    if (frame_chk.mismatches == 0 && frame_chk.frames_due.size() == 0) begin
      $display("wheel_motor_command_sequencer verification clean");
    end else begin
      $display("wheel_motor_command_sequencer verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
